// File: rtl/crlfb_pkg.sv
// Shared types, codes and the LED word formatter for the chained RGB LED frame builder.
// No dependencies; crlfb_ctrl, crlfb_dp and the top level import this package.
package crlfb_pkg;

    // Field widths of one item and one result.
    localparam int LEVEL_W = 8;
    localparam int COLOR_W = 3 * LEVEL_W;
    localparam int WORD_W  = 32;

    // Prefix byte constants of an LED word.
    localparam logic [7:0] PREFIX_BASE = 8'b1100_0000;
    localparam logic [7:0] BIT7_MASK   = 8'h80;
    localparam logic [7:0] BIT6_MASK   = 8'h40;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    // Kind of frame word that the controller asks the datapath to produce.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_LED   = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       wr_en;   // store the accepted color
        logic       issue;   // launch one frame word into the pipeline
        logic [1:0] kind;    // which word is launched
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic can_issue;     // the read stage can take a new word this cycle
        logic in_range;      // the offered LED index lies inside the chain
    } status_t;

    // Builds the 32-bit word for one LED from a blue, green, red entry.
    function automatic logic [WORD_W-1:0] led_word(input logic [COLOR_W-1:0] entry);
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] prefix;
        blue  = entry[23:16];
        green = entry[15:8];
        red   = entry[7:0];
        prefix = PREFIX_BASE;
        prefix[5] = ((blue  & BIT7_MASK) == ZERO_BYTE);
        prefix[4] = ((blue  & BIT6_MASK) == ZERO_BYTE);
        prefix[3] = ((green & BIT7_MASK) == ZERO_BYTE);
        prefix[2] = ((green & BIT6_MASK) == ZERO_BYTE);
        prefix[1] = ((red   & BIT7_MASK) == ZERO_BYTE);
        prefix[0] = ((red   & BIT6_MASK) == ZERO_BYTE);
        return {prefix, blue, green, red};
    endfunction

endpackage

// File: rtl/crlfb_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module crlfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds while rd_en is low.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/crlfb_ctrl.sv
// Frame sequencer: accepts one item, then launches start, LED and end words in order.
// Depends on crlfb_pkg for the command and status structs and the word kinds.
module crlfb_ctrl
    import crlfb_pkg::*;
#(
    parameter int CHAIN_LENGTH = 8,
    localparam int AW = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  status_t       status,
    output cmd_t          cmd,
    output logic [AW-1:0] rd_addr
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_LEDS   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [AW-1:0] LAST_ADDR = AW'(CHAIN_LENGTH - 1);

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;

    // Next state, LED counter and commands.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.kind   = KIND_START;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.wr_en  = status.in_range;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (status.can_issue) begin
                    cmd.issue  = 1'b1;
                    cmd.kind   = KIND_START;
                    cnt_next   = '0;
                    state_next = ST_LEDS;
                end
            end
            ST_LEDS: begin
                if (status.can_issue) begin
                    cmd.issue = 1'b1;
                    cmd.kind  = KIND_LED;
                    if (cnt_reg == LAST_ADDR) begin
                        state_next = ST_FINISH;
                    end else begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (status.can_issue) begin
                    cmd.issue  = 1'b1;
                    cmd.kind   = KIND_END;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = cnt_reg;

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/crlfb_dp.sv
// Datapath: color store with valid bits, read stage and output register.
// Depends on crlfb_pkg and crlfb_ram.
module crlfb_dp
    import crlfb_pkg::*;
#(
    parameter int CHAIN_LENGTH = 8,
    localparam int AW = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       s_tdata,
    input  cmd_t              cmd,
    input  logic [AW-1:0]     rd_addr,
    output status_t           status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,
    output logic              m_tlast
);

    localparam logic [LEVEL_W-1:0] CHAIN_LIMIT = LEVEL_W'(CHAIN_LENGTH);

    logic [LEVEL_W-1:0] led_index;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;

    logic [CHAIN_LENGTH-1:0] valid_reg, valid_next;
    logic                    rd_valid_reg;
    logic [COLOR_W-1:0]      rd_data;
    logic                    rd_en;

    logic                    s1_vld_reg, s1_vld_next;
    logic [1:0]              s1_kind_reg, s1_kind_next;

    logic                    out_vld_reg, out_vld_next;
    logic [WORD_W-1:0]       out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic                    s1_load;
    logic [COLOR_W-1:0]      entry;

    // Unpack the input item.
    assign led_index   = s_tdata[7:0];
    assign red_level   = s_tdata[15:8];
    assign green_level = s_tdata[23:16];
    assign blue_level  = s_tdata[31:24];

    assign out_free = !out_vld_reg || m_tready;
    assign s1_load  = !s1_vld_reg || out_free;
    assign rd_en    = cmd.issue && (cmd.kind == KIND_LED);

    assign status.can_issue = s1_load;
    assign status.in_range  = (led_index < CHAIN_LIMIT);

    // Color store, one entry per LED.
    crlfb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (CHAIN_LENGTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (led_index[AW-1:0]),
        .wr_data ({blue_level, green_level, red_level}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // An entry never written since reset reads as zero.
    always_comb begin
        valid_next = valid_reg;
        if (cmd.wr_en) begin
            valid_next[led_index[AW-1:0]] = 1'b1;
        end
    end

    assign entry = rd_valid_reg ? rd_data : '0;

    // Read stage: tracks the kind of word whose store data is being fetched.
    always_comb begin
        s1_vld_next  = s1_vld_reg;
        s1_kind_next = s1_kind_reg;
        if (s1_load) begin
            s1_vld_next  = cmd.issue;
            s1_kind_next = cmd.kind;
        end
    end

    // Output register: formats the word once the read stage holds it.
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        if (out_free) begin
            out_vld_next = s1_vld_reg;
            unique case (s1_kind_reg)
                KIND_LED: begin
                    out_data_next = led_word(entry);
                    out_last_next = 1'b0;
                end
                KIND_END: begin
                    out_data_next = '0;
                    out_last_next = 1'b1;
                end
                default: begin
                    out_data_next = '0;
                    out_last_next = 1'b0;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
        s1_kind_reg  <= s1_kind_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/chained_rgb_led_frame_builder.sv
// Chained RGB LED frame builder: updates one LED color per item, then sends the frame.
// The input takes no new item until its whole frame has been launched; the sequencer
// launches one frame word per cycle while the read stage can take a new word.
// Reset (aresetn low, synchronous) clears the valid bit of every stored color, so each reads as zero,
// and empties the pipeline. Depends on crlfb_pkg, crlfb_ctrl, crlfb_dp and crlfb_ram.
module chained_rgb_led_frame_builder
    import crlfb_pkg::*;
#(
    parameter int CHAIN_LENGTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // led_index, red_level, green_level, blue_level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // frame_word
    output logic        m_tlast    // last_word
);

    localparam int AW = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] rd_addr;

    // Frame sequencer.
    crlfb_ctrl #(
        .CHAIN_LENGTH (CHAIN_LENGTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    // Store and word pipeline.
    crlfb_dp #(
        .CHAIN_LENGTH (CHAIN_LENGTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/crlfb_checker.sv
// Port-level checks for the chained RGB LED frame builder, bound to the top level.
// Depends only on the top level's ports.
module crlfb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // An accepted item blocks the input; the assertion checks that ready drops right after the accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // The closing word of a frame is all zero.
    a_end_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 32'h0)
        else $error("end word is not zero");

    // Every nonzero word is an LED word with its two leading ones.
    a_led_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata != 32'h0) |-> m_tdata[31:30] == 2'b11)
        else $error("LED word without its leading ones");

    // Reset leaves no word on the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A stalled word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

endmodule

bind chained_rgb_led_frame_builder crlfb_checker u_crlfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for chained_rgb_led_frame_builder: color updates go in,
// full frames come out. Depends on rtl/crlfb_pkg.sv and the RTL of the block;
// every frame word is checked against a local predictor.
module testbench;
    import crlfb_pkg::*;

    localparam int CHAIN_LEN     = 8;
    localparam int RANDOM_ITEMS  = 392;
    localparam int TAIL_CYCLES   = 24;
    localparam int STALL_LIMIT   = 2000;
    localparam int DIRECTED_ROWS = 18;

    // One row of the directed table; a pinned word replaces the predicted word
    // for the addressed LED.
    typedef struct packed {
        logic [7:0]        led_index;
        logic [7:0]        red_level;
        logic [7:0]        green_level;
        logic [7:0]        blue_level;
        logic              pinned;
        logic [WORD_W-1:0] pinned_word;
    } color_update_t;

    // One frame word as the result channel carries it.
    typedef struct packed {
        logic [WORD_W-1:0] frame_word;
        logic              last_word;
    } frame_word_t;

    localparam color_update_t UPDATE_TABLE [DIRECTED_ROWS] = '{
        // First update after reset: dark LED, every prefix bit set.
        '{8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 32'hFF00_0000},
        '{8'd1,   8'hFF, 8'hFF, 8'hFF, 1'b1, 32'hC0FF_FFFF},
        // Last LED of the chain, each top bit pair in a different state.
        '{8'd7,   8'h80, 8'h40, 8'hC0, 1'b1, 32'hC9C0_4080},
        '{8'd2,   8'h40, 8'h80, 8'h3F, 1'b1, 32'hF63F_8040},
        // Indexes outside the chain leave the store alone but still send a frame.
        '{8'd8,   8'hFF, 8'hFF, 8'hFF, 1'b0, 32'h0},
        '{8'd255, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
        // Same LED and same color again still rewrites and resends.
        '{8'd1,   8'hFF, 8'hFF, 8'hFF, 1'b1, 32'hC0FF_FFFF},
        '{8'd3,   8'h7F, 8'hBF, 8'h01, 1'b0, 32'h0},
        '{8'd4,   8'hC0, 8'h00, 8'hFF, 1'b0, 32'h0},
        '{8'd5,   8'h3F, 8'h7F, 8'h80, 1'b0, 32'h0},
        '{8'd6,   8'h55, 8'hAA, 8'h0F, 1'b0, 32'h0},
        '{8'd128, 8'h12, 8'h34, 8'h56, 1'b0, 32'h0},
        '{8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 32'hFF00_0000},
        '{8'd6,   8'h00, 8'h00, 8'h00, 1'b1, 32'hFF00_0000},
        '{8'd9,   8'hAA, 8'h55, 8'hF0, 1'b0, 32'h0},
        '{8'd127, 8'h80, 8'h80, 8'h80, 1'b0, 32'h0},
        '{8'd3,   8'hFF, 8'h00, 8'hFF, 1'b1, 32'hCCFF_00FF},
        '{8'd5,   8'h01, 8'h02, 8'h04, 1'b0, 32'h0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // Local copy of the chain's colors, blue in the top byte, red in the bottom.
    logic [COLOR_W-1:0] chain_colors [CHAIN_LEN];
    frame_word_t        pending_words [$];
    int                 error_count = 0;
    int                 burst_left  = 1;

    chained_rgb_led_frame_builder #(
        .CHAIN_LENGTH(CHAIN_LEN)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Appends one expected frame word behind those already waiting.
    function automatic void queue_word(input frame_word_t word);
        pending_words = {pending_words, word};
    endfunction

    // Picks a color level, favoring the values that flip the prefix bits.
    function automatic logic [7:0] pick_level();
        logic [7:0] corner;
        case ($urandom_range(0, 5))
            0: corner = 8'h00;
            1: corner = 8'hFF;
            2: corner = {2'($urandom_range(0, 3)), 6'($urandom_range(0, 63))};
            default: corner = 8'($urandom_range(0, 255));
        endcase
        return corner;
    endfunction

    // Offers one color update, then queues the frame that it must produce.
    task automatic send_update(input logic [7:0] idx, input logic [7:0] red,
                               input logic [7:0] green, input logic [7:0] blue,
                               input logic pinned, input logic [WORD_W-1:0] pinned_word);
        logic [COLOR_W-1:0] color;
        logic [7:0]         prefix;
        frame_word_t        word;
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red, idx};
        do @(posedge aclk); while (!s_tready);

        if (idx < CHAIN_LEN)
            chain_colors[idx] = {blue, green, red};

        queue_word('{frame_word: '0, last_word: 1'b0});
        for (int i = 0; i < CHAIN_LEN; i++) begin
            color  = chain_colors[i];
            // The prefix carries the inverted top two bits of blue, green and red.
            prefix = PREFIX_BASE | {2'b00, ~color[23], ~color[22], ~color[15], ~color[14],
                                    ~color[7], ~color[6]};
            word.frame_word = {prefix, color};
            word.last_word  = 1'b0;
            if (pinned && i == idx)
                word.frame_word = pinned_word;
            queue_word(word);
        end
        queue_word('{frame_word: '0, last_word: 1'b1});

        // The sender works in bursts; a gap drops valid for a random while.
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Receiver stalls follow a rotating pattern that is redrawn each time pattern_age wraps.
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [5:0]  pattern_age   = '0;

    always @(posedge aclk) begin
        pattern_age <= pattern_age + 6'd1;
        m_tready    <= ready_pattern[0];
        if (pattern_age == '0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern <= 16'hFFFF;
                1: ready_pattern <= 16'($urandom);
                2: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
                default: ready_pattern <= 16'($urandom | $urandom);
            endcase
        end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // Every accepted frame word is checked against the oldest queued word.
    always @(posedge aclk) begin : check_frame_words
        frame_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $error("frame_word 0x%08h arrived with nothing expected", m_tdata);
                error_count++;
            end else begin
                want = pending_words.pop_front();
                if (m_tdata !== want.frame_word) begin
                    $error("frame_word: expected 0x%08h, got 0x%08h", want.frame_word, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last_word) begin
                    $error("last_word: expected %0b, got %0b", want.last_word, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge aclk) begin : watchdog
        int quiet_cycles;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] idx;
        for (int i = 0; i < CHAIN_LEN; i++)
            chain_colors[i] = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table first.
        foreach (UPDATE_TABLE[row])
            send_update(UPDATE_TABLE[row].led_index, UPDATE_TABLE[row].red_level,
                        UPDATE_TABLE[row].green_level, UPDATE_TABLE[row].blue_level,
                        UPDATE_TABLE[row].pinned, UPDATE_TABLE[row].pinned_word);

        // Random updates, mostly inside the chain; the sender drains once halfway.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_words.size() != 0);
            end
            if ($urandom_range(0, 6) == 0)
                idx = 8'($urandom_range(CHAIN_LEN, 255));
            else
                idx = 8'($urandom_range(0, CHAIN_LEN - 1));
            send_update(idx, pick_level(), pick_level(), pick_level(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_words.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/crlfb_pkg.sv
rtl/crlfb_ram.sv
rtl/crlfb_ctrl.sv
rtl/crlfb_dp.sv
rtl/chained_rgb_led_frame_builder.sv
rtl/crlfb_checker.sv
dv/testbench.sv
